/* rtl/fdh_pkg.sv */
// fdh_pkg: shared constants, types and helpers for the fan duty hysteresis controller
// no dependencies; used by every rtl file of the block
`default_nettype none

package fdh_pkg;

   // fan masks
   localparam int NUM_FANS = 6;
   localparam int MASK_W   = 6;

   // only the low NUM_FANS mask bits count; fans beyond the mask width read as absent
   localparam logic [MASK_W-1:0] FAN_MASK = (NUM_FANS >= MASK_W) ?
                                            {MASK_W{1'b1}} :
                                            MASK_W'((1 << NUM_FANS) - 1);
   localparam logic FANS_UNMAPPED = (NUM_FANS > MASK_W);

   // temperatures and thresholds, signed millicelsius
   localparam int TEMP_W = 18;
   localparam int DUTY_W = 7;

   // threshold register file
   localparam int NUM_REGS  = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_RISE_ONE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_TWO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_TWO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RISE_THREE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_THREE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_FOUR  = 3'd5;

   localparam logic signed [TEMP_W-1:0] RST_RISE_ONE   = 18'sd49500;
   localparam logic signed [TEMP_W-1:0] RST_RISE_TWO   = 18'sd53000;
   localparam logic signed [TEMP_W-1:0] RST_FALL_TWO   = 18'sd42700;
   localparam logic signed [TEMP_W-1:0] RST_RISE_THREE = 18'sd57700;
   localparam logic signed [TEMP_W-1:0] RST_FALL_THREE = 18'sd47700;
   localparam logic signed [TEMP_W-1:0] RST_FALL_FOUR  = 18'sd52700;

   // duty levels
   localparam int LEVEL_W = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_40  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_65  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_80  = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_100 = 2'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_100;

   localparam logic [DUTY_W-1:0] DUTY_40  = 7'd40;
   localparam logic [DUTY_W-1:0] DUTY_65  = 7'd65;
   localparam logic [DUTY_W-1:0] DUTY_80  = 7'd80;
   localparam logic [DUTY_W-1:0] DUTY_100 = 7'd100;

   typedef struct packed {
      logic signed [TEMP_W-1:0] rise_one;
      logic signed [TEMP_W-1:0] rise_two;
      logic signed [TEMP_W-1:0] fall_two;
      logic signed [TEMP_W-1:0] rise_three;
      logic signed [TEMP_W-1:0] fall_three;
      logic signed [TEMP_W-1:0] fall_four;
   } thresholds_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               written;
      logic               status;
   } decision_type;

   function automatic logic [DUTY_W-1:0] duty_of_level(input logic [LEVEL_W-1:0] level);
      logic [DUTY_W-1:0] duty;
      case (level)
         LEVEL_40: duty = DUTY_40;
         LEVEL_65: duty = DUTY_65;
         LEVEL_80: duty = DUTY_80;
         default:  duty = DUTY_100;
      endcase
      return duty;
   endfunction

endpackage

`default_nettype wire

/* rtl/fdh_csr.sv */
// fdh_csr: the six hysteresis threshold registers with their write port
// depends on fdh_pkg
`default_nettype none

module fdh_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [fdh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fdh_pkg::TEMP_W-1:0]         csr_wdata,
   output fdh_pkg::thresholds_type                 thresholds
);

   fdh_pkg::thresholds_type thr_ff;
   fdh_pkg::thresholds_type thr_in;

   always_comb begin
      thr_in = thr_ff;
      if (csr_we) begin
         case (csr_index)
            fdh_pkg::REG_RISE_ONE:   thr_in.rise_one   = signed'(csr_wdata);
            fdh_pkg::REG_RISE_TWO:   thr_in.rise_two   = signed'(csr_wdata);
            fdh_pkg::REG_FALL_TWO:   thr_in.fall_two   = signed'(csr_wdata);
            fdh_pkg::REG_RISE_THREE: thr_in.rise_three = signed'(csr_wdata);
            fdh_pkg::REG_FALL_THREE: thr_in.fall_three = signed'(csr_wdata);
            fdh_pkg::REG_FALL_FOUR:  thr_in.fall_four  = signed'(csr_wdata);
            default:                 thr_in = thr_ff;  // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.rise_one   <= fdh_pkg::RST_RISE_ONE;
         thr_ff.rise_two   <= fdh_pkg::RST_RISE_TWO;
         thr_ff.fall_two   <= fdh_pkg::RST_FALL_TWO;
         thr_ff.rise_three <= fdh_pkg::RST_RISE_THREE;
         thr_ff.fall_three <= fdh_pkg::RST_FALL_THREE;
         thr_ff.fall_four  <= fdh_pkg::RST_FALL_FOUR;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign thresholds = thr_ff;

endmodule

`default_nettype wire

/* rtl/fdh_level_calc.sv */
// fdh_level_calc: fan fault checks, temperature mean and one-step hysteresis decision
// depends on fdh_pkg; purely combinational
`default_nettype none

module fdh_level_calc (
   input  wire logic [fdh_pkg::MASK_W-1:0]         fan_failed_mask,
   input  wire logic [fdh_pkg::MASK_W-1:0]         fan_present_mask,
   input  wire logic signed [fdh_pkg::TEMP_W-1:0]  temp_sensor_a,
   input  wire logic signed [fdh_pkg::TEMP_W-1:0]  temp_sensor_b,
   input  wire logic                               read_error,
   input  wire logic [fdh_pkg::LEVEL_W-1:0]        level,
   input  wire fdh_pkg::thresholds_type            thresholds,
   output fdh_pkg::decision_type                   decision
);

   logic                             fan_fault;
   logic signed [fdh_pkg::TEMP_W:0]  temp_sum;
   logic signed [fdh_pkg::TEMP_W:0]  temp_sum_adj;
   logic signed [fdh_pkg::TEMP_W-1:0] temp_mean;
   logic [fdh_pkg::LEVEL_W-1:0]      next_level;

   // failed fan or absent fan, masked to the fans that exist
   assign fan_fault = ((fan_failed_mask & fdh_pkg::FAN_MASK) != '0) ||
                      ((fan_present_mask & fdh_pkg::FAN_MASK) != fdh_pkg::FAN_MASK) ||
                      fdh_pkg::FANS_UNMAPPED;

   // halve with truncation toward zero: bias negative sums by one before the shift
   assign temp_sum     = (fdh_pkg::TEMP_W+1)'(temp_sensor_a) +
                         (fdh_pkg::TEMP_W+1)'(temp_sensor_b);
   assign temp_sum_adj = temp_sum + {{fdh_pkg::TEMP_W{1'b0}}, temp_sum[fdh_pkg::TEMP_W]};
   assign temp_mean    = temp_sum_adj[fdh_pkg::TEMP_W:1];

   // rising test wins over falling
   always_comb begin
      next_level = level;
      case (level)
         fdh_pkg::LEVEL_40: begin
            if (temp_mean >= thresholds.rise_one) next_level = fdh_pkg::LEVEL_65;
         end
         fdh_pkg::LEVEL_65: begin
            if (temp_mean >= thresholds.rise_two) next_level = fdh_pkg::LEVEL_80;
            else if (temp_mean <= thresholds.fall_two) next_level = fdh_pkg::LEVEL_40;
         end
         fdh_pkg::LEVEL_80: begin
            if (temp_mean >= thresholds.rise_three) next_level = fdh_pkg::LEVEL_100;
            else if (temp_mean <= thresholds.fall_three) next_level = fdh_pkg::LEVEL_65;
         end
         default: begin
            if (temp_mean <= thresholds.fall_four) next_level = fdh_pkg::LEVEL_80;
         end
      endcase
   end

   always_comb begin
      if (read_error) begin
         decision.level   = fdh_pkg::LEVEL_TOP;
         decision.written = 1'b1;
         decision.status  = 1'b1;
      end else if (fan_fault) begin
         decision.level   = fdh_pkg::LEVEL_TOP;
         decision.written = 1'b1;
         decision.status  = 1'b0;
      end else begin
         decision.level   = next_level;
         decision.written = (next_level != level);
         decision.status  = 1'b0;
      end
   end

endmodule

`default_nettype wire

/* rtl/fan_duty_hysteresis_controller_core.sv */
// fan_duty_hysteresis_controller_core: top level, input register, level state, result register
// depends on fdh_pkg, fdh_csr, fdh_level_calc
// path: a request is registered in the input stage, then in the result register; rsp_stall can hold both
// throughput: one transfer per cycle while req_stall is low; the only loop is the level register feeding the decision
// reset (synchronous, active high): level goes to 100 percent, thresholds to their defaults,
// both pipeline stages empty; no clearing pass
// req_stall rises only when the input stage is full and the held result is stalled
`default_nettype none

module fan_duty_hysteresis_controller_core (
   input  wire logic                               clock,
   input  wire logic                               reset,

   // request channel
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [fdh_pkg::MASK_W-1:0]         req_fan_failed_mask,
   input  wire logic [fdh_pkg::MASK_W-1:0]         req_fan_present_mask,
   input  wire logic signed [fdh_pkg::TEMP_W-1:0]  req_temp_sensor_a,
   input  wire logic signed [fdh_pkg::TEMP_W-1:0]  req_temp_sensor_b,
   input  wire logic                               req_read_error,

   // result channel
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [fdh_pkg::DUTY_W-1:0]         rsp_duty_percent,
   output      logic                               rsp_duty_written,
   output      logic                               rsp_status,

   // threshold write port
   input  wire logic                               csr_we,
   input  wire logic [fdh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fdh_pkg::TEMP_W-1:0]         csr_wdata
);

   // input stage
   logic                                s1_valid_ff, s1_valid_in;
   logic [fdh_pkg::MASK_W-1:0]          s1_failed_ff;
   logic [fdh_pkg::MASK_W-1:0]          s1_present_ff;
   logic signed [fdh_pkg::TEMP_W-1:0]   s1_temp_a_ff;
   logic signed [fdh_pkg::TEMP_W-1:0]   s1_temp_b_ff;
   logic                                s1_read_error_ff;

   // level state, updated together with the result register
   logic [fdh_pkg::LEVEL_W-1:0]         level_ff, level_in;

   // result stage
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [fdh_pkg::DUTY_W-1:0]          rsp_duty_ff;
   logic                                rsp_written_ff;
   logic                                rsp_status_ff;

   logic                                req_take;
   logic                                s1_move;
   fdh_pkg::thresholds_type             thresholds;
   fdh_pkg::decision_type               decision;

   fdh_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .thresholds (thresholds)
   );

   fdh_level_calc u_level_calc (
      .fan_failed_mask  (s1_failed_ff),
      .fan_present_mask (s1_present_ff),
      .temp_sensor_a    (s1_temp_a_ff),
      .temp_sensor_b    (s1_temp_b_ff),
      .read_error       (s1_read_error_ff),
      .level            (level_ff),
      .thresholds       (thresholds),
      .decision         (decision)
   );

   // handshake: input stage moves on whenever the result slot is free or being drained
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   assign level_in     = s1_move ? decision.level : level_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= fdh_pkg::LEVEL_TOP;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
      end
   end

   // request payload capture on each accepted transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_failed_ff     <= req_fan_failed_mask;
         s1_present_ff    <= req_fan_present_mask;
         s1_temp_a_ff     <= req_temp_sensor_a;
         s1_temp_b_ff     <= req_temp_sensor_b;
         s1_read_error_ff <= req_read_error;
      end
   end

   // result payload; duty always reflects the level held after this item
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_duty_ff    <= fdh_pkg::duty_of_level(decision.level);
         rsp_written_ff <= decision.written;
         rsp_status_ff  <= decision.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_percent = rsp_duty_ff;
   assign rsp_duty_written = rsp_written_ff;
   assign rsp_status       = rsp_status_ff;

   // shown duty matches the level state, since both load on the same transfer
   a_duty_tracks_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_duty_ff == fdh_pkg::duty_of_level(level_ff)))
      else $error("result duty differs from held level");

   // read error always commands full duty
   a_error_full_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |->
         (rsp_written_ff && rsp_duty_ff == fdh_pkg::DUTY_100))
      else $error("error result without full duty command");

   // level only moves when an item passes into the result stage
   a_level_moves_on_transfer: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && level_ff != $past(level_ff)) |-> $past(s1_move))
      else $error("level changed without a transfer");

   // a change in level is always reported as a duty command
   a_change_is_written: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && level_ff != $past(level_ff)) |-> rsp_written_ff)
      else $error("level change not flagged as written");

   // backpressure only when both stages are occupied
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free stage");

endmodule

`default_nettype wire
